// ===== hw/rtl/anhc_pkg.sv =====
`timescale 1ns / 1ps

package anhc_pkg;

  localparam int CACHE_ENTRIES_DEF = 8;
  localparam int CFG_IDX_W         = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP  = 2'd2;

  localparam logic [31:0] IP_ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [47:0] BROADCAST_MAC = 48'hFFFF_FFFF_FFFF;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_LEARN  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] ip_addr;
    logic [47:0] learn_mac;
  } anhc_in_t;

  typedef struct packed {
    logic        hit;
    logic        is_broadcast;
    logic [47:0] mac_out;
    logic [31:0] next_hop;
  } anhc_out_t;

  // item travelling down the row of cells
  typedef struct packed {
    logic        valid;
    logic        action;
    logic        bcast;
    logic        found;
    logic        free_found;
    logic [31:0] addr;
    logic [47:0] mac;
  } anhc_tok_t;

  // fill of one entry after the item has left the row
  typedef struct packed {
    logic        en;
    logic [31:0] ip;
    logic [47:0] mac;
  } anhc_wr_t;

endpackage

// ===== hw/rtl/arp_next_hop_cache.sv =====
`timescale 1ns / 1ps
// An accepted input is registered into tok0, then the item walks the row of cells
// one entry per cycle; the result is taken from the last cell.
// Only one item is in the row at a time; a new input is not taken until the item
// leaves the row. Results queue in two output slots; input is taken while one waits.
// Reset: synchronous, clears entry valid bits, config registers and control state.

module arp_next_hop_cache
  import anhc_pkg::*;
#(
  parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  anhc_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output anhc_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  logic [31:0] local_ip;
  logic [31:0] subnet_mask;
  logic [31:0] gateway_ip;

  logic        busy;
  logic        in_xfer;
  logic        off_net;
  logic [31:0] hop;
  anhc_tok_t   tok0;

  anhc_tok_t        tok  [CACHE_ENTRIES];
  logic [IDX_W-1:0] free [CACHE_ENTRIES];
  anhc_wr_t         wr   [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] wr_en;
  logic [CACHE_ENTRIES:0]   tok_valid;

  anhc_tok_t   last;
  logic [IDX_W-1:0] last_free;
  anhc_out_t   res;
  anhc_out_t   q0;
  anhc_out_t   q1;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip    <= '0;
      subnet_mask <= '0;
      gateway_ip  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOCAL_IP:    local_ip    <= cfg_data;
        CFG_SUBNET_MASK: subnet_mask <= cfg_data;
        CFG_GATEWAY_IP:  gateway_ip  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = busy || (count == 2'd2);
  assign in_xfer  = in_valid && !in_stall;

  assign off_net = (subnet_mask != '0)
                   && (((in_data.ip_addr ^ local_ip) & subnet_mask) != '0);
  assign hop = (in_data.action == ACT_LOOKUP && off_net) ? gateway_ip : in_data.ip_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      tok0.valid <= 1'b0;
    end else begin
      tok0.valid      <= in_xfer;
      tok0.action     <= in_data.action;
      tok0.bcast      <= (in_data.action == ACT_LOOKUP)
                         && (hop == IP_ALL_ONES || hop == '0);
      tok0.found      <= 1'b0;
      tok0.free_found <= 1'b0;
      tok0.addr       <= hop;
      tok0.mac        <= (in_data.action == ACT_LEARN) ? in_data.learn_mac : '0;
      if (in_xfer) begin
        busy <= 1'b1;
      end else if (last.valid) begin
        busy <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
    anhc_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   ((i == 0) ? tok0 : tok[(i == 0) ? 0 : i - 1]),
      .free_in  ((i == 0) ? '0 : free[(i == 0) ? 0 : i - 1]),
      .wr       (wr[i]),
      .tok_out  (tok[i]),
      .free_out (free[i])
    );

    // miss on learn: fill the lowest free entry, or entry 0 when full
    assign wr_en[i] = last.valid && last.action == ACT_LEARN && !last.found
                      && (last.free_found ? (last_free == IDX_W'(i)) : (i == 0));
    assign wr[i].en  = wr_en[i];
    assign wr[i].ip  = last.addr;
    assign wr[i].mac = last.mac;
    assign tok_valid[i + 1] = tok[i].valid;
  end

  assign tok_valid[0] = tok0.valid;
  assign last         = tok[CACHE_ENTRIES-1];
  assign last_free    = free[CACHE_ENTRIES-1];

  always_comb begin
    res.hit          = last.found || last.bcast;
    res.is_broadcast = last.bcast;
    res.mac_out      = last.bcast ? BROADCAST_MAC
                       : ((last.action == ACT_LOOKUP) ? last.mac : '0);
    res.next_hop     = last.addr;
  end

  assign push      = last.valid;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
      if (push && !pop) begin
        if (count == 2'd0) begin
          q0 <= res;
        end else begin
          q1 <= res;
        end
      end else if (pop && !push) begin
        q0 <= q1;
      end else if (push && pop) begin
        if (count == 2'd1) begin
          q0 <= res;
        end else begin
          q0 <= q1;
          q1 <= res;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_one_in_row: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_valid) <= 1)
    else $error("more than one item in the cell row");

  a_one_fill: assert property (@(posedge clk) disable iff (rst)
    $onehot0(wr_en))
    else $error("more than one entry filled at once");

  a_row_busy: assert property (@(posedge clk) disable iff (rst)
    (tok_valid != '0) |-> busy)
    else $error("item in row while not busy");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    last.valid |-> (count != 2'd2) || pop)
    else $error("result arrives with output queue full");
`endif

endmodule

// ===== hw/rtl/anhc_cell.sv =====
`timescale 1ns / 1ps

module anhc_cell
  import anhc_pkg::*;
#(
  parameter int IDX_W = 3,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  anhc_tok_t        tok_in,
  input  logic [IDX_W-1:0] free_in,
  input  anhc_wr_t         wr,
  output anhc_tok_t        tok_out,
  output logic [IDX_W-1:0] free_out
);

  logic [31:0]      ip;
  logic [47:0]      mac;
  logic             valid;
  logic             match;
  anhc_tok_t        tok_next;
  logic [IDX_W-1:0] free_next;

  assign match = tok_in.valid && valid && !tok_in.found && !tok_in.bcast
                 && (ip == tok_in.addr);

  always_comb begin
    tok_next  = tok_in;
    free_next = free_in;
    if (match) begin
      tok_next.found = 1'b1;
      if (tok_in.action == ACT_LOOKUP) begin
        tok_next.mac = mac;
      end
    end
    if (tok_in.valid && !valid && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      free_next           = IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out  <= tok_next;
      free_out <= free_next;
      if (wr.en) begin
        ip    <= wr.ip;
        mac   <= wr.mac;
        valid <= 1'b1;
      end else if (match && tok_in.action == ACT_LEARN) begin
        mac <= tok_in.mac;
      end
    end
  end

endmodule
